// ===== rtl/core/bdeq_pkg.sv =====
package bdeq_pkg;

  localparam int DEFAULT_DEPTH      = 16;
  localparam int DEFAULT_DATA_WIDTH = 32;

  localparam int MODE_W     = 3;
  localparam int DATA_IO_W  = 32;
  localparam int POSITION_W = 4;
  localparam int STATUS_W   = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_READ_FRONT = 3'd4,
    MODE_READ_BACK  = 3'd5,
    MODE_READ_INDEX = 3'd6,
    MODE_CLEAR      = 3'd7
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_READ = 1'b1
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // take the operation on the input ports now
    logic read_done;  // store read data is valid, finish the read
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic read_go;    // the offered operation is a read that will hit the store
  } dp_stat_t;

endpackage

// ===== rtl/core/bounded_double_ended_queue.sv =====
// Bounded double-ended queue of up to DEPTH entries held in a ring store.
// Start a transaction by raising start while busy is low; mode, data_in and
// position are sampled at that clock edge. Every transaction returns exactly
// one result on data_out, entry_count and status, marked by done for a single
// cycle; the receiver cannot hold results off, so capture them when done is
// high. Pushes, pops, clear and every refused or failed operation report in the
// cycle after the transaction, and busy stays low so a new transaction can be
// started in every cycle. A read that reaches the store (read front, read back
// or read index with a valid position) goes through the store's registered
// read port, so busy is high for the cycle in which the read data comes back,
// and done follows in the next cycle. Status codes are 0 ok, 1 empty, 2 full so
// the push was refused, and 3 position out of range.
// data_out is zero for everything but a successful read. Reset clears the
// head and the count; the store itself is not cleared and is only ever read
// at entries that a push has written. No clearing pass follows reset.
module bounded_double_ended_queue #(
  parameter int DEPTH      = bdeq_pkg::DEFAULT_DEPTH,
  parameter int DATA_WIDTH = bdeq_pkg::DEFAULT_DATA_WIDTH,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [bdeq_pkg::MODE_W-1:0]     mode,
  input  logic [bdeq_pkg::DATA_IO_W-1:0]  data_in,
  input  logic [bdeq_pkg::POSITION_W-1:0] position,
  output logic                            done,
  output logic [bdeq_pkg::DATA_IO_W-1:0]  data_out,
  output logic [CW-1:0]                   entry_count,
  output logic [bdeq_pkg::STATUS_W-1:0]   status
);

  bdeq_pkg::ctrl_cmd_t cmd;
  bdeq_pkg::dp_stat_t  stat;

  // The controller only sequences transactions; it decides when the datapath
  // takes an operation and when a store read is complete.
  bdeq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the head pointer, the entry count, the ring store and
  // the result registers, and works out addresses and status codes.
  bdeq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .mode        (mode),
    .data_in     (data_in),
    .position    (position),
    .done        (done),
    .data_out    (data_out),
    .entry_count (entry_count),
    .status      (status)
  );

endmodule

// ===== rtl/core/bdeq_ram.sv =====
module bdeq_ram #(
  parameter int WIDTH = bdeq_pkg::DEFAULT_DATA_WIDTH,
  parameter int DEPTH = bdeq_pkg::DEFAULT_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bdeq_ctrl.sv =====
module bdeq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  bdeq_pkg::dp_stat_t   stat,
  output bdeq_pkg::ctrl_cmd_t  cmd,
  output logic                 busy
);

  bdeq_pkg::ctrl_state_t state;
  bdeq_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdeq_pkg::CTRL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd.accept    = 1'b0;
    cmd.read_done = 1'b0;
    busy          = 1'b0;
    case (state)
      bdeq_pkg::CTRL_IDLE: begin
        cmd.accept = start;
        // Only a read that reaches the store goes on to the read state.
        if (start && stat.read_go) begin
          state_next = bdeq_pkg::CTRL_READ;
        end
      end
      bdeq_pkg::CTRL_READ: begin
        busy          = 1'b1;
        cmd.read_done = 1'b1;
        state_next    = bdeq_pkg::CTRL_IDLE;
      end
      default: begin
        state_next = bdeq_pkg::CTRL_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bdeq_datapath.sv =====
module bdeq_datapath #(
  parameter int DEPTH      = bdeq_pkg::DEFAULT_DEPTH,
  parameter int DATA_WIDTH = bdeq_pkg::DEFAULT_DATA_WIDTH,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bdeq_pkg::ctrl_cmd_t                 cmd,
  output bdeq_pkg::dp_stat_t                  stat,
  input  logic [bdeq_pkg::MODE_W-1:0]         mode,
  input  logic [bdeq_pkg::DATA_IO_W-1:0]      data_in,
  input  logic [bdeq_pkg::POSITION_W-1:0]     position,
  output logic                                done,
  output logic [bdeq_pkg::DATA_IO_W-1:0]      data_out,
  output logic [CW-1:0]                       entry_count,
  output logic [bdeq_pkg::STATUS_W-1:0]       status
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = (CW > bdeq_pkg::POSITION_W) ? CW : bdeq_pkg::POSITION_W;
  localparam int SW = PW + 1;

  logic [AW-1:0]         head;
  logic [AW-1:0]         head_next;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  bdeq_pkg::mode_t       op;
  bdeq_pkg::status_t     st;
  logic                  full;
  logic                  empty;
  logic [PW-1:0]         off;
  logic [SW-1:0]         slot_sum;
  logic [SW-1:0]         slot_wrap;
  logic [AW-1:0]         slot;
  logic [AW-1:0]         head_dec;
  logic                  wr;
  logic [AW-1:0]         waddr;
  logic                  rd;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata;

  assign op    = bdeq_pkg::mode_t'(mode);
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign wdata = DATA_WIDTH'(data_in);

  // Ring slot at a given distance from the head; wherever the slot is used, the distance is below DEPTH.
  assign slot_sum  = SW'(head) + SW'(off);
  assign slot_wrap = (slot_sum >= SW'(DEPTH)) ? slot_sum - SW'(DEPTH) : slot_sum;
  assign slot      = slot_wrap[AW-1:0];
  assign head_dec  = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);

  always_comb begin
    head_next    = head;
    count_next   = count;
    st           = bdeq_pkg::ST_OK;
    off          = '0;
    wr           = 1'b0;
    waddr        = slot;
    rd           = 1'b0;
    case (op)
      bdeq_pkg::MODE_PUSH_FRONT: begin
        if (full) begin
          st = bdeq_pkg::ST_FULL;
        end else begin
          head_next  = head_dec;
          waddr      = head_dec;
          wr         = 1'b1;
          count_next = count + CW'(1);
        end
      end
      bdeq_pkg::MODE_PUSH_BACK: begin
        off = PW'(count);
        if (full) begin
          st = bdeq_pkg::ST_FULL;
        end else begin
          wr         = 1'b1;
          count_next = count + CW'(1);
        end
      end
      bdeq_pkg::MODE_POP_FRONT: begin
        off = PW'(1);
        if (empty) begin
          st = bdeq_pkg::ST_EMPTY;
        end else begin
          head_next  = slot;
          count_next = count - CW'(1);
        end
      end
      bdeq_pkg::MODE_POP_BACK: begin
        if (empty) begin
          st = bdeq_pkg::ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      bdeq_pkg::MODE_READ_FRONT: begin
        if (empty) begin
          st = bdeq_pkg::ST_EMPTY;
        end else begin
          rd = 1'b1;
        end
      end
      bdeq_pkg::MODE_READ_BACK: begin
        off = PW'(count - CW'(1));
        if (empty) begin
          st = bdeq_pkg::ST_EMPTY;
        end else begin
          rd = 1'b1;
        end
      end
      bdeq_pkg::MODE_READ_INDEX: begin
        off = PW'(position);
        if (empty) begin
          st = bdeq_pkg::ST_EMPTY;
        end else if (PW'(position) >= PW'(count)) begin
          st = bdeq_pkg::ST_RANGE;
        end else begin
          rd = 1'b1;
        end
      end
      bdeq_pkg::MODE_CLEAR: begin
        head_next  = '0;
        count_next = '0;
      end
      default: begin
        head_next = head;
      end
    endcase
  end

  assign stat.read_go = rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        head  <= head_next;
        count <= count_next;
      end
      // A store read reports from the controller's read state, the rest report at once.
      if (cmd.read_done) begin
        done <= 1'b1;
      end else begin
        done <= cmd.accept && !rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      entry_count <= count_next;
      status      <= st;
      data_out    <= '0;
    end
    if (cmd.read_done) begin
      data_out <= bdeq_pkg::DATA_IO_W'(rdata);
    end
  end

  bdeq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.accept && wr),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.accept && rd),
    .raddr (slot),
    .rdata (rdata)
  );

endmodule
